// ===== sv/nonpreemptive_priority_scheduler_macros.svh =====
// Assertion macros shared by the scheduler RTL files.
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define NPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define NPS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/nps_pkg.sv =====
// Types and constants shared by the scheduler modules.
`default_nettype none

package nps_pkg;

  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned TIME_W    = 24;
  localparam int unsigned JOB_IDX_W = 4;
  // Job count field wide enough for the largest supported capacity (64).
  localparam int unsigned SET_CNT_W = 7;

  typedef struct packed {
    logic [FIELD_W-1:0] priority_req;
    logic [FIELD_W-1:0] burst;
    logic [FIELD_W-1:0] arrival;
    logic               last_job;
  } in_item_t;

  typedef struct packed {
    logic [JOB_IDX_W-1:0] job_index;
    logic [TIME_W-1:0]    start_at;
    logic [TIME_W-1:0]    finish_at;
    logic [TIME_W-1:0]    turnaround;
    logic [TIME_W-1:0]    waiting;
    logic                 last_result;
    logic                 dropped;
  } out_item_t;

  // One stored job in the job table.
  typedef struct packed {
    logic [FIELD_W-1:0] prio;
    logic [FIELD_W-1:0] burst;
    logic [FIELD_W-1:0] arrival;
  } job_entry_t;

  localparam int unsigned JOB_ENTRY_W = $bits(job_entry_t);

  // Descriptor of one fully loaded job set.
  typedef struct packed {
    logic                 ovf;
    logic [SET_CNT_W-1:0] cnt;
  } set_desc_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_EMIT
  } back_state_e;

endpackage

`default_nettype wire

// ===== sv/nps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nps_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/nps_queue.sv =====
// Two-entry queue of loaded job sets; each entry owns one table bank.
`default_nettype none

module nps_queue
  import nps_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire set_desc_t push_desc_i,
  input  wire logic      pop_i,
  output      logic      full_o,
  output      logic      valid_o,
  output      set_desc_t head_o,
  output      logic      wr_ptr_o,
  output      logic      rd_ptr_o
);

  set_desc_t  entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Descriptor storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

  assign full_o   = (cnt_q == 2'd2);
  assign valid_o  = (cnt_q != 2'd0);
  assign head_o   = entry_q[rd_ptr_q];
  assign wr_ptr_o = wr_ptr_q;
  assign rd_ptr_o = rd_ptr_q;

`include "nonpreemptive_priority_scheduler_macros.svh"

  `NPS_NEVER(a_no_push_full, push_i && full_o && !pop_i, "push into a full queue")
  `NPS_NEVER(a_no_pop_empty, pop_i && !valid_o, "pop from an empty queue")
  `NPS_ASSERT(a_ptr_gap, (cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q), "pointers out of step")

endmodule

`default_nettype wire

// ===== sv/nps_front.sv =====
// Front end: takes job transfers, writes the job table, hands off complete sets.
`default_nettype none

module nps_front
  import nps_pkg::*;
#(
  parameter int unsigned MAX_JOBS = 16,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire in_item_t         in_data_i,
  input  wire logic             q_full_i,
  output      logic             push_o,
  output      set_desc_t        push_desc_o,
  output      logic             wr_en_o,
  output      logic [IDX_W-1:0] wr_idx_o,
  output      job_entry_t       wr_data_o
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_JOBS);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             accept;
  logic             has_room;

  // A set is loaded into the free bank only.
  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign has_room   = (cnt_q < MAX_CNT);

  // Store the job when there is room, otherwise note the overflow.
  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (has_room) begin
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  assign wr_en_o   = accept & has_room;
  assign wr_idx_o  = cnt_q[IDX_W-1:0];
  assign wr_data_o = '{prio: in_data_i.priority_req, burst: in_data_i.burst,
                       arrival: in_data_i.arrival};

  // The final job of a set closes it and passes it to the back end.
  assign push_o          = accept & in_data_i.last_job;
  assign push_desc_o.ovf = ovf_d;
  assign push_desc_o.cnt = SET_CNT_W'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (push_o) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/nps_back.sv =====
// Back end: selection scans over the job table and result generation.
`default_nettype none

module nps_back
  import nps_pkg::*;
#(
  parameter int unsigned MAX_JOBS = 16,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire set_desc_t        q_head_i,
  input  wire logic             bank_i,
  output      logic             pop_o,
  output      logic [IDX_W:0]   rd_addr_o,
  input  wire job_entry_t       rd_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      out_item_t        out_data_o
);

  back_state_e state_q, state_d;

  logic [CNT_W-1:0]    n_q, k_q, iss_q;
  logic                ovf_q;
  logic [TIME_W-1:0]   t_q;
  logic [MAX_JOBS-1:0] done_q;
  logic                rv_q;
  logic [IDX_W-1:0]    ridx_q;

  // Candidate among arrived jobs: smallest priority, lowest index.
  logic               a_found_q;
  logic [FIELD_W-1:0] a_prio_q, a_burst_q, a_arr_q;
  logic [IDX_W-1:0]   a_idx_q;
  // Fallback candidate: earliest arrival, then smallest priority, lowest index.
  logic               b_found_q;
  logic [FIELD_W-1:0] b_prio_q, b_burst_q, b_arr_q;
  logic [IDX_W-1:0]   b_idx_q;

  // Selected job.
  logic [IDX_W-1:0]   p_idx_q;
  logic [TIME_W-1:0]  p_start_q, p_fin_q, p_wait_q;
  logic [FIELD_W-1:0] p_arr_q;

  logic              out_valid_q;
  out_item_t         out_q;

  logic              issue, start_scan, scan_done, slot_free, last, emit;
  logic              look, elig, upd_a, upd_b;
  logic [TIME_W-1:0] sel_start;
  logic [FIELD_W-1:0] sel_burst, sel_arr;
  logic [IDX_W-1:0]  sel_idx;

  assign slot_free = ~out_valid_q | out_ready_i;
  assign last      = ((k_q + CNT_W'(1)) == n_q);
  assign scan_done = (iss_q == n_q) & ~rv_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (q_valid_i) state_d = ST_SCAN;
      ST_SCAN: if (scan_done) state_d = ST_CALC;
      ST_CALC: state_d = ST_EMIT;
      ST_EMIT: if (slot_free) state_d = last ? ST_IDLE : ST_SCAN;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    issue      = 1'b0;
    start_scan = 1'b0;
    emit       = 1'b0;
    pop_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: start_scan = q_valid_i;
      ST_SCAN: issue = (iss_q != n_q);
      ST_CALC: ;
      ST_EMIT: begin
        emit       = slot_free;
        start_scan = slot_free & ~last;
        pop_o      = slot_free & last;
      end
      default: ;
    endcase
  end

  assign rd_addr_o = {bank_i, iss_q[IDX_W-1:0]};

  // Compare the entry that arrives from the table against both candidates.
  assign look  = rv_q & ~done_q[ridx_q];
  assign elig  = (TIME_W'(rd_data_i.arrival) <= t_q);
  assign upd_a = look & elig & (~a_found_q | (rd_data_i.prio < a_prio_q));
  assign upd_b = look & (~b_found_q |
                 ({rd_data_i.arrival, rd_data_i.prio} < {b_arr_q, b_prio_q}));

  // With nothing arrived, time jumps to the fallback candidate's arrival.
  always_comb begin
    if (a_found_q) begin
      sel_start = t_q;
      sel_burst = a_burst_q;
      sel_arr   = a_arr_q;
      sel_idx   = a_idx_q;
    end else begin
      sel_start = TIME_W'(b_arr_q);
      sel_burst = b_burst_q;
      sel_arr   = b_arr_q;
      sel_idx   = b_idx_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      k_q         <= '0;
      iss_q       <= '0;
      ovf_q       <= 1'b0;
      t_q         <= '0;
      done_q      <= '0;
      rv_q        <= 1'b0;
      a_found_q   <= 1'b0;
      b_found_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= issue;
      if (state_q == ST_IDLE && q_valid_i) begin
        n_q    <= q_head_i.cnt[CNT_W-1:0];
        ovf_q  <= q_head_i.ovf;
        k_q    <= '0;
        t_q    <= '0;
        done_q <= '0;
      end
      if (start_scan) begin
        iss_q     <= '0;
        a_found_q <= 1'b0;
        b_found_q <= 1'b0;
      end else begin
        if (issue) iss_q <= iss_q + CNT_W'(1);
        if (upd_a) a_found_q <= 1'b1;
        if (upd_b) b_found_q <= 1'b1;
      end
      if (emit) begin
        t_q             <= p_fin_q;
        done_q[p_idx_q] <= 1'b1;
        k_q             <= k_q + CNT_W'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    ridx_q <= iss_q[IDX_W-1:0];
    if (upd_a) begin
      a_prio_q  <= rd_data_i.prio;
      a_burst_q <= rd_data_i.burst;
      a_arr_q   <= rd_data_i.arrival;
      a_idx_q   <= ridx_q;
    end
    if (upd_b) begin
      b_prio_q  <= rd_data_i.prio;
      b_burst_q <= rd_data_i.burst;
      b_arr_q   <= rd_data_i.arrival;
      b_idx_q   <= ridx_q;
    end
    if (state_q == ST_CALC) begin
      p_idx_q   <= sel_idx;
      p_start_q <= sel_start;
      p_fin_q   <= sel_start + TIME_W'(sel_burst);
      p_wait_q  <= sel_start - TIME_W'(sel_arr);
      p_arr_q   <= sel_arr;
    end
    if (emit) begin
      out_q.job_index   <= JOB_IDX_W'(p_idx_q);
      out_q.start_at    <= p_start_q;
      out_q.finish_at   <= p_fin_q;
      out_q.turnaround  <= p_fin_q - TIME_W'(p_arr_q);
      out_q.waiting     <= p_wait_q;
      out_q.last_result <= last;
      out_q.dropped     <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "nonpreemptive_priority_scheduler_macros.svh"

  `NPS_ASSERT(a_pick_exists, (state_q == ST_CALC) |-> (a_found_q || b_found_q),
              "no candidate found by a selection scan")
  `NPS_ASSERT(a_pick_pending, (state_q == ST_EMIT) |-> !done_q[p_idx_q],
              "finished job selected again")
  `NPS_ASSERT(a_count_bound, (state_q != ST_IDLE) |-> (k_q < n_q && iss_q <= n_q),
              "result or scan count beyond the set size")

endmodule

`default_nettype wire

// ===== sv/nonpreemptive_priority_scheduler.sv =====
// Top level of the non-preemptive priority scheduler.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one job per transfer,
// with priority, burst and arrival time; last_job closes the set. Loading
// takes one transfer per cycle while in_ready_o is high. Jobs past MAX_JOBS
// are discarded and every result of that set carries dropped.
// Output channel (out_valid_o / out_ready_i / out_data_o): one result per
// stored job, in execution order, last_result on the final one.
// Two table banks sit behind a two-entry set queue, so a new set loads while
// the previous one is scheduled; in_ready_o drops only when both banks hold
// sets that are not yet finished.
// Each result costs one selection scan over the set's n jobs through the
// table's single read port. A stalled receiver holds the result register;
// the scan engine waits on it. Reset empties the queue and both ends; table
// contents need no clearing.
`default_nettype none

module nonpreemptive_priority_scheduler
  import nps_pkg::*;
#(
  parameter int unsigned MAX_JOBS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_ready_o,
  input  wire in_item_t  in_data_i,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      out_item_t out_data_o
);

  localparam int unsigned IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
  localparam int unsigned RAM_DEPTH = 2 ** (IDX_W + 1);

  logic             q_full, q_valid, q_push, q_pop, wr_ptr, rd_ptr;
  set_desc_t        push_desc, q_head;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  job_entry_t       wr_data, rd_data;
  logic [IDX_W:0]   rd_addr;
  logic [JOB_ENTRY_W-1:0] rd_bits;

  nps_front #(
    .MAX_JOBS(MAX_JOBS),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .push_desc_o(push_desc),
    .wr_en_o    (wr_en),
    .wr_idx_o   (wr_idx),
    .wr_data_o  (wr_data)
  );

  // Job table: one bank per queue entry.
  nps_ram #(
    .WIDTH(JOB_ENTRY_W),
    .DEPTH(RAM_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i({wr_ptr, wr_idx}),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rd_bits)
  );

  assign rd_data = job_entry_t'(rd_bits);

  nps_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_desc_i(push_desc),
    .pop_i      (q_pop),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .wr_ptr_o   (wr_ptr),
    .rd_ptr_o   (rd_ptr)
  );

  nps_back #(
    .MAX_JOBS(MAX_JOBS),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_head_i   (q_head),
    .bank_i     (rd_ptr),
    .pop_o      (q_pop),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== tb/nps_schedule_checker.sv =====
// Scoreboard for the scheduler: predicts each job set's schedule and checks every result.
`default_nettype none

module nps_schedule_checker
  import nps_pkg::*;
#(
  parameter int unsigned MAX_JOBS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_ready_i,
  input  wire in_item_t  in_data_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_ready_i,
  input  wire out_item_t out_data_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_count_o,
  output int unsigned    set_count_o,
  output int unsigned    dropped_set_count_o,
  output int unsigned    result_count_o
);

  typedef struct packed {
    logic [FIELD_W-1:0] prio;
    logic [FIELD_W-1:0] burst;
    logic [FIELD_W-1:0] arrival;
  } job_rec_t;

  // Jobs of the set currently being loaded, as the block should hold them.
  job_rec_t    job_table [MAX_JOBS];
  int unsigned jobs_held = 0;
  logic        jobs_lost = 1'b0;

  // Results still owed by the block, oldest first.
  out_item_t   expected_results [$];

  // Index of the best arrived, unfinished job at time now, or -1 if none.
  function automatic int find_ready(logic [TIME_W-1:0] now, logic [MAX_JOBS-1:0] finished);
    int                 pick;
    logic [FIELD_W-1:0] best;
    pick = -1;
    best = '0;
    for (int j = 0; j < int'(jobs_held); j++) begin
      // Strict compare keeps the lowest index on a priority tie.
      if (!finished[j] && job_table[j].arrival <= now &&
          (pick < 0 || job_table[j].prio < best)) begin
        pick = j;
        best = job_table[j].prio;
      end
    end
    return pick;
  endfunction

  // Run the whole set to completion and queue one result per job.
  task automatic schedule_set();
    logic [MAX_JOBS-1:0] finished;
    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   earliest;
    logic                seen;
    int                  pick;
    out_item_t           res;
    finished = '0;
    now      = '0;
    for (int k = 0; k < int'(jobs_held); k++) begin
      pick = find_ready(now, finished);
      if (pick < 0) begin
        // Nothing has arrived yet: jump to the earliest pending arrival.
        seen     = 1'b0;
        earliest = '0;
        for (int j = 0; j < int'(jobs_held); j++) begin
          if (!finished[j] && (!seen || job_table[j].arrival < earliest)) begin
            seen     = 1'b1;
            earliest = job_table[j].arrival;
          end
        end
        now  = earliest;
        pick = find_ready(now, finished);
      end
      res.job_index   = pick[JOB_IDX_W-1:0];
      res.start_at    = now;
      res.finish_at   = now + job_table[pick].burst;
      res.turnaround  = res.finish_at - job_table[pick].arrival;
      res.waiting     = res.turnaround - job_table[pick].burst;
      res.last_result = (k == int'(jobs_held) - 1);
      res.dropped     = jobs_lost;
      expected_results.push_back(res);
      now            = res.finish_at;
      finished[pick] = 1'b1;
    end
    jobs_held = 0;
    jobs_lost = 1'b0;
  endtask

  task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  // Compare one result transfer against the oldest expectation.
  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $error("result for job %0d arrived with no result expected", got.job_index);
      fail_count_o++;
    end else begin
      want = expected_results.pop_front();
      check_field("job_index", TIME_W'(want.job_index), TIME_W'(got.job_index));
      check_field("start_at", want.start_at, got.start_at);
      check_field("finish_at", want.finish_at, got.finish_at);
      check_field("turnaround", want.turnaround, got.turnaround);
      check_field("waiting", want.waiting, got.waiting);
      check_field("last_result", TIME_W'(want.last_result), TIME_W'(got.last_result));
      check_field("dropped", TIME_W'(want.dropped), TIME_W'(got.dropped));
    end
  endtask

  // Watch both channels on every rising edge outside reset.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        result_count_o++;
        check_result(out_data_i);
      end
      if (in_valid_i && in_ready_i) begin
        if (jobs_held < MAX_JOBS) begin
          job_table[jobs_held] = '{prio:    in_data_i.priority_req,
                                   burst:   in_data_i.burst,
                                   arrival: in_data_i.arrival};
          jobs_held++;
        end else begin
          jobs_lost = 1'b1;
        end
        if (in_data_i.last_job) begin
          set_count_o++;
          if (jobs_lost) begin
            dropped_set_count_o++;
          end
          schedule_set();
        end
      end
      pending_count_o = expected_results.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Top of the scheduler testbench: clock, reset, job stimulus, result back-pressure and verdict.
`default_nettype none

module tb;
  import nps_pkg::*;

  localparam int unsigned JOB_CAP       = 16;
  localparam int unsigned RANDOM_PER_PH = 32;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      job_valid = 1'b0;
  in_item_t  job_data  = '0;
  logic      job_ready;
  logic      res_valid;
  logic      res_ready = 1'b0;
  out_item_t res_data;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned jobs_sent      = 0;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned set_count;
  int unsigned dropped_set_count;
  int unsigned result_count;

  nonpreemptive_priority_scheduler #(
    .MAX_JOBS(JOB_CAP)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (job_valid),
    .in_ready_o (job_ready),
    .in_data_i  (job_data),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .out_data_o (res_data)
  );

  nps_schedule_checker #(
    .MAX_JOBS(JOB_CAP)
  ) u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (job_valid),
    .in_ready_i         (job_ready),
    .in_data_i          (job_data),
    .out_valid_i        (res_valid),
    .out_ready_i        (res_ready),
    .out_data_i         (res_data),
    .fail_count_o       (fail_count),
    .pending_count_o    (pending_count),
    .set_count_o        (set_count),
    .dropped_set_count_o(dropped_set_count),
    .result_count_o     (result_count)
  );

  always #1 clk = ~clk;

  // Random back-pressure on the result channel.
  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One job transfer, preceded by a random idle gap on the sender side.
  task automatic push_job(input logic [FIELD_W-1:0] prio, input logic [FIELD_W-1:0] burst,
                          input logic [FIELD_W-1:0] arrival, input logic last);
    int unsigned gap;
    in_item_t    item;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      job_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.priority_req = prio;
    item.burst        = burst;
    item.arrival      = arrival;
    item.last_job     = last;
    job_valid <= 1'b1;
    job_data  <= item;
    do begin
      @(posedge clk);
    end while (!job_ready);
    jobs_sent++;
  endtask

  // A set of random size and flavor; a few sets overflow the job table.
  task automatic random_set();
    int unsigned n;
    int unsigned pick;
    int unsigned flavor;
    pick   = $urandom_range(99);
    flavor = $urandom_range(2);
    if (pick < 65) begin
      n = $urandom_range(5, 1);
    end else if (pick < 90) begin
      n = $urandom_range(JOB_CAP, 6);
    end else begin
      n = $urandom_range(JOB_CAP + 4, JOB_CAP + 1);
    end
    for (int i = 0; i < int'(n); i++) begin
      case (flavor)
        0: begin
          push_job(FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                   i == int'(n) - 1);
        end
        1: begin
          // Few priority levels and close arrivals: ties, zero bursts, idle gaps.
          push_job(FIELD_W'($urandom_range(3)), FIELD_W'($urandom_range(12)),
                   FIELD_W'($urandom_range(40)), i == int'(n) - 1);
        end
        default: begin
          push_job(FIELD_W'($urandom), FIELD_W'($urandom_range(65535)),
                   FIELD_W'($urandom_range(3)), i == int'(n) - 1);
        end
      endcase
    end
  endtask

  initial begin
    int unsigned goal;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single job with every field at its maximum.
    push_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    // Idle start, priority tie broken by index, zero burst, then an idle jump.
    push_job(16'd5, 16'd3, 16'd10, 1'b0);
    push_job(16'd2, 16'd0, 16'd10, 1'b0);
    push_job(16'd2, 16'd4, 16'd10, 1'b0);
    push_job(16'd0, 16'd7, 16'd40, 1'b1);
    // Full table of longest bursts, then a discarded job that closes the set.
    for (int i = 0; i < int'(JOB_CAP); i++) begin
      push_job(FIELD_W'($urandom), 16'hFFFF, 16'd0, 1'b0);
    end
    push_job(16'd0, 16'd0, 16'd0, 1'b1);

    // Random sets under four pressure profiles.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      goal = jobs_sent + RANDOM_PER_PH;
      while (jobs_sent < goal) begin
        random_set();
      end
    end
    job_valid <= 1'b0;

    // Drain, then watch a while longer for stray results.
    @(posedge clk);
    while (pending_count != 0) begin
      @(posedge clk);
    end
    repeat (JOB_CAP * (JOB_CAP + 3) + 64) @(posedge clk);

    $display("Loaded %0d jobs in %0d sets (%0d of them overflowing the table).",
             jobs_sent, set_count, dropped_set_count);
    $display("Checked %0d results across idle-free, sender-idle, receiver-stall and mixed phases.",
             result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hang guard: far beyond every set at full size with heavy stalls on both sides.
  initial begin
    #800000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
